@@ hw/rtl/vsc_pkg.sv @@
// Package for the Vigenere stream cipher unit: beat types, register codes and lookup tables.
package vsc_pkg;

    // Alphabet and key geometry.
    localparam int SYMBOL_COUNT  = 66;
    localparam int ALPHABET_SIZE = 66;
    localparam int MAX_KEY_LEN   = 8;
    localparam int EFF_SIZE      = (ALPHABET_SIZE < SYMBOL_COUNT) ? ALPHABET_SIZE : SYMBOL_COUNT;

    localparam int KEY_LEN_W    = 4;
    localparam int KEY_POS_W    = 3;
    localparam int SHIFT_W      = 7;
    localparam int KEY_SHIFTS_W = 56;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 56;

    localparam logic [KEY_LEN_W-1:0]    KEY_LEN_RESET    = 4'd2;
    localparam logic [KEY_SHIFTS_W-1:0] KEY_SHIFTS_RESET = 56'd129;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_LENGTH = 2'd0,
        REG_KEY_SHIFTS = 2'd1
    } t_cfg_reg;

    typedef struct packed {
        logic       command;
        logic [7:0] char_in;
        logic       start_message;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] char_out;
        logic       passed_through;
    } t_out_beat;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_beat;

    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    typedef logic [7:0]         t_byte_lut  [128];
    typedef logic [7:0]         t_idx_lut   [256];
    typedef logic [SHIFT_W-1:0] t_shift_lut [128];

    // Symbols in index order: a..z, n-tilde, hyphen, A..Z, comma, period, 0..9.
    localparam logic [7:0] SYMBOLS [SYMBOL_COUNT] = '{
        8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h6A, 8'h6B,
        8'h6C, 8'h6D, 8'h6E, 8'h6F, 8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h76,
        8'h77, 8'h78, 8'h79, 8'h7A,
        8'hF1, 8'h2D,
        8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4A, 8'h4B,
        8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56,
        8'h57, 8'h58, 8'h59, 8'h5A,
        8'h2C, 8'h2E,
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39
    };

    // Index to byte, padded to the full 7-bit index range.
    function automatic t_byte_lut f_byte_lut();
        t_byte_lut lut;
        for (int i = 0; i < 128; i++) begin
            lut[i] = (i < SYMBOL_COUNT) ? SYMBOLS[i] : 8'h00;
        end
        return lut;
    endfunction

    // Byte to {found, index}; the first matching symbol wins.
    function automatic t_idx_lut f_idx_lut();
        t_idx_lut lut;
        for (int b = 0; b < 256; b++) begin
            lut[b] = 8'h00;
            for (int i = EFF_SIZE - 1; i >= 0; i--) begin
                if (SYMBOLS[i] == 8'(b)) begin
                    lut[b] = {1'b1, 7'(i)};
                end
            end
        end
        return lut;
    endfunction

    // Raw 7-bit key shift reduced modulo the effective alphabet size.
    function automatic t_shift_lut f_shift_lut();
        t_shift_lut lut;
        for (int i = 0; i < 128; i++) begin
            lut[i] = SHIFT_W'(i % EFF_SIZE);
        end
        return lut;
    endfunction

    localparam t_byte_lut  BYTE_LUT  = f_byte_lut();
    localparam t_idx_lut   IDX_LUT   = f_idx_lut();
    localparam t_shift_lut SHIFT_LUT = f_shift_lut();

endpackage

@@ hw/rtl/vsc_if.sv @@
// Handshake interfaces for the input, result and configuration channels.
interface vsc_in_if;
    logic               valid;
    logic               ready;
    vsc_pkg::t_in_beat  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface vsc_out_if;
    logic               valid;
    logic               ready;
    vsc_pkg::t_out_beat data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface vsc_cfg_if;
    logic               valid;
    logic               ready;
    vsc_pkg::t_cfg_beat data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/vigenere_stream_cipher_unit.sv @@
// Top level of the Vigenere stream cipher unit.
//
// The unit encrypts or decrypts a stream of Latin-1 bytes over a 66-symbol
// alphabet with a Vigenere key of up to eight shifts. Input beats arrive on
// i_in (command, char_in, start_message) and one result beat per input leaves
// on o_out (char_out, passed_through). Bytes outside the alphabet are copied
// unchanged with passed_through set, and they still advance the key.
// Key length and packed key shifts are written over i_cfg, which is always
// ready; write it only while no beat is in flight.
// The datapath is two register stages: the input stage captures the byte and
// the selected key shift, the output stage holds the finished result. One beat
// is accepted every cycle while the receiver keeps up, limited only by the table
// lookups and the modular add in between.
// When the receiver stalls, the result stays in the output register and the
// input stage still fills once, so the sender sees backpressure one beat
// later. A synchronous active-low reset empties both stages, puts the key
// position back to zero and restores key length 2 and key "bb".
module vigenere_stream_cipher_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vsc_in_if.sink     i_in,
    vsc_out_if.source  o_out,
    vsc_cfg_if.sink    i_cfg
);

    // Configuration registers.
    logic [vsc_pkg::KEY_LEN_W-1:0]    r_key_len;
    logic [vsc_pkg::KEY_SHIFTS_W-1:0] r_key_shifts;

    // Key position for the next byte.
    logic [vsc_pkg::KEY_POS_W-1:0] r_key_pos, n_key_pos;

    // Input stage.
    logic                        r_s1_vld;
    logic                        r_s1_cmd;
    logic [7:0]                  r_s1_byte;
    logic [vsc_pkg::SHIFT_W-1:0] r_s1_shift;

    // Output stage.
    logic               r_out_vld;
    vsc_pkg::t_out_beat r_out, n_out;

    logic in_acc;
    logic out_adv;
    logic s1_adv;

    // The output register can load when it is empty or being drained; the input
    // stage moves forward whenever the output can take its contents.
    assign out_adv = !r_out_vld || o_out.ready;
    assign s1_adv  = out_adv;
    assign i_in.ready = !r_s1_vld || s1_adv;
    assign in_acc  = i_in.valid && i_in.ready;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_len    <= vsc_pkg::KEY_LEN_RESET;
            r_key_shifts <= vsc_pkg::KEY_SHIFTS_RESET;
        end else if (i_cfg.valid) begin
            case (vsc_pkg::t_cfg_reg'(i_cfg.data.index))
                vsc_pkg::REG_KEY_LENGTH: r_key_len <= i_cfg.data.data[vsc_pkg::KEY_LEN_W-1:0];
                vsc_pkg::REG_KEY_SHIFTS: r_key_shifts <= i_cfg.data.data;
                default: ;
            endcase
        end
    end

    // Key selection at the input: clamp the length, restart on start_message,
    // and fall back to position zero if the length was lowered below it.
    logic [vsc_pkg::KEY_LEN_W-1:0] eff_len;
    logic [vsc_pkg::KEY_POS_W-1:0] pos;
    logic [vsc_pkg::SHIFT_W-1:0]   raw_shift;

    always_comb begin
        if (r_key_len == '0) begin
            eff_len = vsc_pkg::KEY_LEN_W'(1);
        end else if (r_key_len > vsc_pkg::KEY_LEN_W'(vsc_pkg::MAX_KEY_LEN)) begin
            eff_len = vsc_pkg::KEY_LEN_W'(vsc_pkg::MAX_KEY_LEN);
        end else begin
            eff_len = r_key_len;
        end
        pos = i_in.data.start_message ? '0 : r_key_pos;
        if ({1'b0, pos} >= eff_len) begin
            pos = '0;
        end
        raw_shift = r_key_shifts[vsc_pkg::SHIFT_W * pos +: vsc_pkg::SHIFT_W];
        n_key_pos = pos + vsc_pkg::KEY_POS_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_pos <= '0;
            r_s1_vld  <= 1'b0;
        end else begin
            if (in_acc) begin
                r_key_pos <= n_key_pos;
            end
            if (i_in.ready) begin
                r_s1_vld <= i_in.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_cmd   <= i_in.data.command;
            r_s1_byte  <= i_in.data.char_in;
            r_s1_shift <= vsc_pkg::SHIFT_LUT[raw_shift];
        end
    end

    // Output stage logic: alphabet lookup, modular add or subtract, map back.
    logic [7:0] lut_ent;
    logic       found;
    logic [7:0] u;
    logic [7:0] sh;
    logic [7:0] sum;
    logic [7:0] res;

    localparam logic [7:0] N = 8'(vsc_pkg::EFF_SIZE);

    always_comb begin
        lut_ent = vsc_pkg::IDX_LUT[r_s1_byte];
        found   = lut_ent[7];
        u       = {1'b0, lut_ent[6:0]};
        sh      = {1'b0, r_s1_shift};
        sum     = u + sh;
        if (r_s1_cmd == vsc_pkg::CMD_DECRYPT) begin
            res = (u >= sh) ? (u - sh) : (u + N - sh);
        end else begin
            res = (sum >= N) ? (sum - N) : sum;
        end
        if (found) begin
            n_out.char_out       = vsc_pkg::BYTE_LUT[res[6:0]];
            n_out.passed_through = 1'b0;
        end else begin
            n_out.char_out       = r_s1_byte;
            n_out.passed_through = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_adv) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_s1_vld) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

    // A restarted message always leaves the key at its second entry.
    a_start_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in.data.start_message |=> r_key_pos == vsc_pkg::KEY_POS_W'(1))
        else $error("key position not advanced after start of message");

    // A stalled result is never dropped.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !o_out.ready |=> r_out_vld && $stable(r_out))
        else $error("stalled result lost or changed");

    // A waiting input stage keeps its beat until the output can take it.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !s1_adv |=> r_s1_vld && $stable(r_s1_byte) && $stable(r_s1_shift))
        else $error("input stage beat lost while stalled");

    // A transformed byte always lies in the alphabet.
    a_in_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_out.passed_through |-> vsc_pkg::IDX_LUT[r_out.char_out][7])
        else $error("cipher output outside alphabet");

endmodule

@@ tb/sv/vsc_stream_checker.sv @@
// Cipher predictor and result comparator that watches the unit's three channels.
`timescale 1ns / 100ps

module vsc_stream_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  vsc_pkg::t_in_beat  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  vsc_pkg::t_out_beat i_out_data,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  vsc_pkg::t_cfg_beat i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int               ALPHA_N           = 66;
    localparam int               MAX_SHIFTS        = 8;
    localparam logic [3:0]       KEY_LEN_AT_RESET  = 4'd2;
    localparam logic [55:0]      KEY_KEYS_AT_RESET = 56'd129;

    logic [3:0]         key_len_q;
    logic [55:0]        key_shifts_q;
    logic [2:0]         key_pos_q;
    vsc_pkg::t_out_beat cipher_expected_q[$];
    int                 fail_count;
    int                 pending_cnt;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_cnt;

    // Alphabet order: a..z, n-tilde, hyphen, A..Z, comma, period, 0..9.
    function automatic logic [7:0] symbol_at(int idx);
        if (idx < 26) return 8'h61 + 8'(idx);
        if (idx == 26) return 8'hF1;
        if (idx == 27) return 8'h2D;
        if (idx < 54) return 8'h41 + 8'(idx - 28);
        if (idx == 54) return 8'h2C;
        if (idx == 55) return 8'h2E;
        return 8'h30 + 8'(idx - 56);
    endfunction

    function automatic int symbol_index(logic [7:0] b);
        for (int i = 0; i < ALPHA_N; i++) begin
            if (symbol_at(i) == b) return i;
        end
        return -1;
    endfunction

    function automatic vsc_pkg::t_out_beat cipher_byte(input vsc_pkg::t_in_beat b,
                                                       input logic [3:0] len_raw,
                                                       input logic [55:0] shifts,
                                                       input logic [2:0] pos_in,
                                                       output logic [2:0] pos_next);
        vsc_pkg::t_out_beat r;
        int                 len;
        int                 pos;
        int                 shift;
        int                 idx;
        int                 res;
        len = (len_raw == 0) ? 1 : ((len_raw > MAX_SHIFTS) ? MAX_SHIFTS : int'(len_raw));
        pos = b.start_message ? 0 : int'(pos_in);
        if (pos >= len) pos = 0;
        shift = int'(shifts[7*pos +: 7]) % ALPHA_N;
        pos_next = 3'(pos + 1);
        idx = symbol_index(b.char_in);
        if (idx < 0) begin
            r.char_out       = b.char_in;
            r.passed_through = 1'b1;
        end else begin
            if (b.command == vsc_pkg::CMD_DECRYPT) begin
                res = (idx >= shift) ? idx - shift : idx + ALPHA_N - shift;
            end else begin
                res = idx + shift;
                if (res >= ALPHA_N) res -= ALPHA_N;
            end
            r.char_out       = symbol_at(res);
            r.passed_through = 1'b0;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : track
        vsc_pkg::t_out_beat want;
        vsc_pkg::t_out_beat got;
        logic [2:0]         pos_nxt;
        if (!i_rst_n) begin
            key_len_q    <= KEY_LEN_AT_RESET;
            key_shifts_q <= KEY_KEYS_AT_RESET;
            key_pos_q    <= '0;
            cipher_expected_q.delete();
            fail_count  = 0;
            pending_cnt = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_data.index)
                    vsc_pkg::REG_KEY_LENGTH: key_len_q    <= i_cfg_data.data[3:0];
                    vsc_pkg::REG_KEY_SHIFTS: key_shifts_q <= i_cfg_data.data[55:0];
                    default: ;
                endcase
            end
            // Results are matched before this edge's input is queued, so a result can
            // never be paired with an input accepted at the same edge.
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (cipher_expected_q.size() == 0) begin
                    $error("result beat char_out %h with no expectation waiting",
                           got.char_out);
                    fail_count++;
                end else begin
                    want = cipher_expected_q.pop_front();
                    if (got.char_out !== want.char_out) begin
                        $error("char_out: expected %h, actual %h",
                               want.char_out, got.char_out);
                        fail_count++;
                    end
                    if (got.passed_through !== want.passed_through) begin
                        $error("passed_through: expected %b, actual %b",
                               want.passed_through, got.passed_through);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                want = cipher_byte(i_in_data, key_len_q, key_shifts_q, key_pos_q, pos_nxt);
                cipher_expected_q.push_back(want);
                key_pos_q <= pos_nxt;
            end
            pending_cnt = cipher_expected_q.size();
        end
    end

endmodule

@@ tb/sv/testbench.sv @@
// Top of the cipher unit testbench: clock, reset, stimulus and the final verdict.
`timescale 1ns / 100ps

module testbench;

    // The limit leaves a wide margin over the slowest correct run.
    localparam int CYCLE_LIMIT = 100000;
    localparam int CHUNK_ITEMS = 118;
    localparam int CHUNKS      = 4;

    // Register indexes that decode to nothing; writes to them must leave the key alone.
    localparam logic [vsc_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [vsc_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    logic i_clk;
    logic i_rst_n;
    int   in_idle_pct;
    int   out_idle_pct;
    int   fail_count;
    int   pending;
    int   cycle_count;

    vsc_in_if  in_ch ();
    vsc_out_if out_ch ();
    vsc_cfg_if cfg_ch ();

    vigenere_stream_cipher_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    vsc_stream_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_ch.valid),
        .i_in_ready   (in_ch.ready),
        .i_in_data    (in_ch.data),
        .i_out_valid  (out_ch.valid),
        .i_out_ready  (out_ch.ready),
        .i_out_data   (out_ch.data),
        .i_cfg_valid  (cfg_ch.valid),
        .i_cfg_ready  (cfg_ch.ready),
        .i_cfg_data   (cfg_ch.data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // The receiver decides at every falling edge whether it takes a beat at the next
    // rising edge. The idle share changes per phase of the run.
    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // A random byte from the alphabet, spread over its letter, digit and sign groups.
    function automatic logic [7:0] pick_symbol();
        case ($urandom_range(3))
            0: return 8'h61 + 8'($urandom_range(25));
            1: return 8'h41 + 8'($urandom_range(25));
            2: return 8'h30 + 8'($urandom_range(9));
            default: begin
                case ($urandom_range(3))
                    0: return 8'hF1;
                    1: return 8'h2D;
                    2: return 8'h2C;
                    default: return 8'h2E;
                endcase
            end
        endcase
    endfunction

    // Offers one input beat and returns once it has been taken. Idle cycles are put in
    // front of it at random; valid only ever changes at a falling edge, and only once
    // there, so a beat that follows another keeps valid high without a glitch.
    task automatic send_byte(logic cmd, logic [7:0] ch, logic start);
        @(negedge i_clk);
        while ($urandom_range(99) < in_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= '{command: cmd, char_in: ch, start_message: start};
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // Stops the sender and waits until every predicted result has come back, then lets
    // the two register stages settle. Returns at a falling edge.
    task automatic hold_until_drained();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    // Register writes only happen with the datapath empty.
    task automatic write_reg(logic [vsc_pkg::CFG_IDX_W-1:0] idx,
                             logic [vsc_pkg::CFG_DATA_W-1:0] value);
        hold_until_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= '{index: idx, data: value};
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [vsc_pkg::CFG_DATA_W-1:0] len_word;
        logic [vsc_pkg::CFG_DATA_W-1:0] shifts;
        logic                           cmd;
        logic                           start;
        logic [7:0]                     ch;

        // Every input of the unit is known from time zero on.
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        cycle_count  = 0;
        in_idle_pct  = 13;
        out_idle_pct = 61;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, with the reset key "bb" over two positions. The first beats
        // walk both ends of every alphabet group, so the encrypt wrap from the last
        // digit back to 'a' is hit.
        send_byte(vsc_pkg::CMD_ENCRYPT, 8'h61, 1'b1);
        send_byte(vsc_pkg::CMD_ENCRYPT, 8'h7A, 1'b0);
        send_byte(vsc_pkg::CMD_ENCRYPT, 8'hF1, 1'b0);
        send_byte(vsc_pkg::CMD_ENCRYPT, 8'h2D, 1'b0);
        send_byte(vsc_pkg::CMD_ENCRYPT, 8'h41, 1'b0);
        send_byte(vsc_pkg::CMD_ENCRYPT, 8'h5A, 1'b0);
        send_byte(vsc_pkg::CMD_ENCRYPT, 8'h2C, 1'b0);
        send_byte(vsc_pkg::CMD_ENCRYPT, 8'h2E, 1'b0);
        send_byte(vsc_pkg::CMD_ENCRYPT, 8'h30, 1'b0);
        send_byte(vsc_pkg::CMD_ENCRYPT, 8'h39, 1'b0);
        // Bytes outside the alphabet are copied through and still move the key.
        send_byte(vsc_pkg::CMD_ENCRYPT, 8'h00, 1'b0);
        send_byte(vsc_pkg::CMD_ENCRYPT, 8'hFF, 1'b0);
        // Decrypting 'a' wraps below index zero to the last digit.
        send_byte(vsc_pkg::CMD_DECRYPT, 8'h61, 1'b1);
        send_byte(vsc_pkg::CMD_DECRYPT, 8'h39, 1'b0);

        // A key length of zero acts as one, and shift entries of 66 and above are
        // reduced modulo the alphabet size.
        write_reg(vsc_pkg::REG_KEY_LENGTH, '0);
        write_reg(vsc_pkg::REG_KEY_SHIFTS, '1);
        send_byte(vsc_pkg::CMD_ENCRYPT, 8'h61, 1'b0);
        send_byte(vsc_pkg::CMD_DECRYPT, 8'h61, 1'b0);

        // Run the key position up to six, then shorten the key below it: the next
        // byte without a start flag must fall back to position zero.
        write_reg(vsc_pkg::REG_KEY_LENGTH, 56'd8);
        write_reg(vsc_pkg::REG_KEY_SHIFTS, 56'({$urandom, $urandom}));
        repeat (5) send_byte(vsc_pkg::CMD_ENCRYPT, pick_symbol(), 1'b0);
        write_reg(vsc_pkg::REG_KEY_LENGTH, 56'd2);
        send_byte(vsc_pkg::CMD_ENCRYPT, pick_symbol(), 1'b0);

        // A key length above eight saturates to eight.
        write_reg(vsc_pkg::REG_KEY_LENGTH, 56'd15);
        send_byte(vsc_pkg::CMD_DECRYPT, pick_symbol(), 1'b0);
        send_byte(vsc_pkg::CMD_DECRYPT, pick_symbol(), 1'b0);

        // Random part in three phases: a stalling receiver, then a slow sender, then
        // full rate on both sides. The key changes between chunks of each phase.
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    in_idle_pct  = 13;
                    out_idle_pct = 61;
                end
                1: begin
                    in_idle_pct  = 61;
                    out_idle_pct = 13;
                end
                default: begin
                    in_idle_pct  = 0;
                    out_idle_pct = 0;
                end
            endcase
            for (int ck = 0; ck < CHUNKS; ck++) begin
                // Upper data bits of the length word are noise the unit must ignore.
                len_word = 56'({$urandom, $urandom});
                case ($urandom_range(5))
                    0: len_word[3:0] = 4'd1;
                    1: len_word[3:0] = 4'd8;
                    2: len_word[3:0] = 4'd0;
                    3: len_word[3:0] = 4'd15;
                    default: len_word[3:0] = 4'($urandom_range(15));
                endcase
                write_reg(vsc_pkg::REG_KEY_LENGTH, len_word);
                case ($urandom_range(4))
                    0: shifts = '0;
                    1: shifts = '1;
                    default: shifts = 56'({$urandom, $urandom});
                endcase
                write_reg(vsc_pkg::REG_KEY_SHIFTS, shifts);
                if ($urandom_range(3) == 0) begin
                    write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI,
                              56'({$urandom, $urandom}));
                end
                for (int n = 0; n < CHUNK_ITEMS; n++) begin
                    // Now and then the sender waits for the pipeline to empty out.
                    if (n == 60 || $urandom_range(199) == 0) hold_until_drained();
                    cmd   = 1'($urandom_range(1));
                    start = ($urandom_range(15) == 0);
                    ch    = ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : pick_symbol();
                    send_byte(cmd, ch, start);
                end
            end
        end

        // Let the last results out, then give the pipeline time to show any extra beat.
        hold_until_drained();
        repeat (8) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/vsc_pkg.sv
hw/rtl/vsc_if.sv
hw/rtl/vigenere_stream_cipher_unit.sv
tb/sv/vsc_stream_checker.sv
tb/sv/testbench.sv
